>>> hw/rtl/fpsr_pkg.sv
`default_nettype none
package fpsr_pkg;
	localparam int MAX_LOG2_SIZE_DEF = 10;
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int IDX_BITS          = 11;
	localparam int SHIFT_BITS        = 16;
	localparam int LOG2_BITS         = 4;
	localparam int PHASE_BITS        = 16;
	localparam int CORDIC_STAGES     = 16;
	localparam int CW                = 34;
	localparam logic signed [CW-1:0] CORDIC_K30 = 34'sd652032874;

	localparam logic [1:0] REG_SHIFT_COL = 2'd0;
	localparam logic [1:0] REG_SHIFT_ROW = 2'd1;
	localparam logic [1:0] REG_LOG2_COLS = 2'd2;
	localparam logic [1:0] REG_LOG2_ROWS = 2'd3;

	function automatic logic signed [CW-1:0] atan_turn(input int i);
		case (i)
			0: atan_turn = 34'sd536870912;
			1: atan_turn = 34'sd316933406;
			2: atan_turn = 34'sd167458907;
			3: atan_turn = 34'sd85004756;
			4: atan_turn = 34'sd42667331;
			5: atan_turn = 34'sd21354465;
			6: atan_turn = 34'sd10679838;
			7: atan_turn = 34'sd5340245;
			8: atan_turn = 34'sd2670163;
			9: atan_turn = 34'sd1335087;
			10: atan_turn = 34'sd667544;
			11: atan_turn = 34'sd333772;
			12: atan_turn = 34'sd166886;
			13: atan_turn = 34'sd83443;
			14: atan_turn = 34'sd41722;
			default: atan_turn = 34'sd20861;
		endcase
	endfunction

	typedef struct packed {
		logic [PHASE_BITS-1:0] phase;
		logic                  last;
	} fpsr_tag_t;
endpackage
`default_nettype wire

>>> hw/rtl/fpsr_front.sv
`default_nettype none
module fpsr_front import fpsr_pkg::*; #(
	parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic signed [IDX_BITS-1:0]   col_index,
	input  wire logic signed [IDX_BITS-1:0]   row_index,
	input  wire logic signed [SHIFT_BITS-1:0] shift_col,
	input  wire logic signed [SHIFT_BITS-1:0] shift_row,
	input  wire logic [LOG2_BITS-1:0]         log2_cols,
	input  wire logic [LOG2_BITS-1:0]         log2_rows,
	input  wire logic                         last_in,
	output logic                              tag_valid,
	input  wire logic                         tag_ready,
	output fpsr_tag_t                         tag
);
	localparam int FRAC = 8 + MAX_LOG2_SIZE;
	localparam int PW   = IDX_BITS + SHIFT_BITS + MAX_LOG2_SIZE + 1;
	localparam int D    = FRAC - PHASE_BITS;

	logic signed [IDX_BITS+SHIFT_BITS-1:0] pc_s1, pr_s1;
	logic [LOG2_BITS-1:0] sc_s1, sr_s1;
	logic last_s1, v_s1;
	logic [PW-1:0] sum;
	logic [PW-1:0] tc, tr;
	logic [PHASE_BITS-1:0] ph;
	logic adv;

	assign adv = !tag_valid || tag_ready;
	assign in_ready = adv;

	function automatic logic [LOG2_BITS-1:0] sh_amt(input logic [LOG2_BITS-1:0] l);
		sh_amt = (l > LOG2_BITS'(MAX_LOG2_SIZE)) ? '0 : LOG2_BITS'(MAX_LOG2_SIZE) - l;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			pc_s1   <= col_index * shift_col;
			pr_s1   <= row_index * shift_row;
			sc_s1   <= sh_amt(log2_cols);
			sr_s1   <= sh_amt(log2_rows);
			last_s1 <= last_in;
		end
	end

	always_comb begin
		tc  = PW'(pc_s1) << sc_s1;
		tr  = PW'(pr_s1) << sr_s1;
		sum = tc + tr;
		if (D > 0) begin
			ph = PHASE_BITS'((sum + (PW'(1) << (D > 0 ? D - 1 : 0))) >> (D > 0 ? D : 0));
		end else begin
			ph = PHASE_BITS'(sum << (D > 0 ? 0 : -D));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_valid <= 1'b0;
		end else if (adv) begin
			tag_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag.phase <= ph;
			tag.last  <= last_s1;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/fpsr_back.sv
`default_nettype none
module fpsr_back import fpsr_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tag_valid,
	output logic                               tag_ready,
	input  wire fpsr_tag_t                     tag,
	input  wire logic signed [SAMPLE_BITS-1:0] re_in,
	input  wire logic signed [SAMPLE_BITS-1:0] im_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [2*SAMPLE_BITS:0]             out_data
);
	localparam int N  = CORDIC_STAGES;
	localparam int PW = SAMPLE_BITS + CW + 1;

	logic adv;
	assign adv = !out_valid || out_ready;
	assign tag_ready = adv;

	logic [N:0] v_c;
	logic signed [CW-1:0] x_c [N+1];
	logic signed [CW-1:0] y_c [N+1];
	logic signed [CW-1:0] z_c [N+1];
	logic [1:0] q_c [N+1];
	logic l_c [N+1];
	logic signed [SAMPLE_BITS-1:0] re_c [N+1];
	logic signed [SAMPLE_BITS-1:0] im_c [N+1];

	logic [1:0] q0;
	logic [PHASE_BITS-1:0] r0;
	assign q0 = 2'((tag.phase + 16'h2000) >> 14);
	assign r0 = tag.phase - {q0, 14'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_c[0] <= 1'b0;
		end else if (adv) begin
			v_c[0] <= tag_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_c[0]  <= CORDIC_K30;
			y_c[0]  <= '0;
			z_c[0]  <= CW'($signed(r0)) <<< 16;
			q_c[0]  <= q0;
			l_c[0]  <= tag.last;
			re_c[0] <= re_in;
			im_c[0] <= im_in;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_c[i+1] <= 1'b0;
			end else if (adv) begin
				v_c[i+1] <= v_c[i];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!z_c[i][CW-1]) begin
					x_c[i+1] <= x_c[i] - (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] + (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] - atan_turn(i);
				end else begin
					x_c[i+1] <= x_c[i] + (y_c[i] >>> i);
					y_c[i+1] <= y_c[i] - (x_c[i] >>> i);
					z_c[i+1] <= z_c[i] + atan_turn(i);
				end
				q_c[i+1]  <= q_c[i];
				l_c[i+1]  <= l_c[i];
				re_c[i+1] <= re_c[i];
				im_c[i+1] <= im_c[i];
			end
		end
	end

	logic signed [CW-1:0] cs, sn;
	always_comb begin
		case (q_c[N])
			2'd0: begin cs = x_c[N];  sn = y_c[N];  end
			2'd1: begin cs = -y_c[N]; sn = x_c[N];  end
			2'd2: begin cs = -x_c[N]; sn = -y_c[N]; end
			default: begin cs = y_c[N]; sn = -x_c[N]; end
		endcase
	end

	logic signed [PW-1:0] rc_s1, is_s1, ic_s1, rs_s1;
	logic v_m1, l_m1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
		end else if (adv) begin
			v_m1 <= v_c[N];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			rc_s1 <= PW'(re_c[N]) * PW'(cs);
			is_s1 <= PW'(im_c[N]) * PW'(sn);
			ic_s1 <= PW'(im_c[N]) * PW'(cs);
			rs_s1 <= PW'(re_c[N]) * PW'(sn);
			l_m1  <= l_c[N];
		end
	end

	function automatic logic [SAMPLE_BITS-1:0] rnd_sat(input logic signed [PW:0] v);
		logic signed [PW:0] r;
		logic signed [PW:0] hi;
		logic signed [PW:0] lo;
		r  = (v + (PW+1)'(1 << 29)) >>> 30;
		hi = (PW+1)'((1 << (SAMPLE_BITS-1)) - 1);
		lo = -hi - 1;
		if (r > hi) rnd_sat = hi[SAMPLE_BITS-1:0];
		else if (r < lo) rnd_sat = lo[SAMPLE_BITS-1:0];
		else rnd_sat = r[SAMPLE_BITS-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_m1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= {l_m1,
				rnd_sat((PW+1)'(ic_s1) - (PW+1)'(rs_s1)),
				rnd_sat((PW+1)'(rc_s1) + (PW+1)'(is_s1))};
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/fourier_phase_shift_rotator_unit.sv
// Fourier phase-shift rotator.
// Input stream s_axis: one coefficient per transfer with its signed column and
// row frequency indices. The block rotates it by exp(-i*2*pi*t), where t is
// col*shift_col/2^(log2_cols+8) + row*shift_row/2^(log2_rows+8) in turns, rounds
// to nearest and saturates. tlast passes through with its coefficient.
// Output stream m_axis: one transfer per input transfer, in order.
// Throughput: one transfer per cycle unless the receiver stalls. A transfer
// passes the two phase stages, the quadrant entry stage, the 16-stage CORDIC,
// the multiply stage and the output register.
// The back half (CORDIC, multiply, output register) advances as one pipeline
// whenever the output register is empty or its transfer is taken; a stalled
// receiver (m_axis_tready low with a result held) freezes it. The front half
// feeds it through a one-entry tag register and keeps advancing until that
// register is full and blocked, then s_axis_tready drops.
// Configuration via APB: 0x0 shift_col, 0x4 shift_row, 0x8 log2_cols,
// 0xC log2_rows. Write only while the stream is idle.
// Reset clears all valid flags and loads shifts 0 and log2 sizes 8.
`default_nettype none
module fourier_phase_shift_rotator_unit import fpsr_pkg::*; #(
	parameter int MAX_LOG2_SIZE = MAX_LOG2_SIZE_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_axis_tvalid,
	output logic                            s_axis_tready,
	// col_index[10:0], row_index[21:11], src_re, src_im, zero pad
	input  wire logic [((2*IDX_BITS+2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  wire logic                       s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  wire logic                       m_axis_tready,
	// dst_re, dst_im, zero pad
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic                            m_axis_tlast,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [3:0]                 paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	localparam int OW = ((2*SAMPLE_BITS+7)/8)*8;

	logic signed [SHIFT_BITS-1:0] shift_col_q, shift_row_q;
	logic [LOG2_BITS-1:0] log2_cols_q, log2_rows_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// hold registers until an APB write lands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_col_q <= '0;
			shift_row_q <= '0;
			log2_cols_q <= LOG2_BITS'(8);
			log2_rows_q <= LOG2_BITS'(8);
		end else if (wr) begin
			case (paddr[3:2])
				REG_SHIFT_COL: shift_col_q <= pwdata[SHIFT_BITS-1:0];
				REG_SHIFT_ROW: shift_row_q <= pwdata[SHIFT_BITS-1:0];
				REG_LOG2_COLS: log2_cols_q <= pwdata[LOG2_BITS-1:0];
				default:       log2_rows_q <= pwdata[LOG2_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SHIFT_COL: prdata = 32'(unsigned'(shift_col_q));
			REG_SHIFT_ROW: prdata = 32'(unsigned'(shift_row_q));
			REG_LOG2_COLS: prdata = 32'(log2_cols_q);
			default:       prdata = 32'(log2_rows_q);
		endcase
	end

	// samples ride alongside the phase front stages
	localparam int SB = 2*IDX_BITS;
	logic signed [SAMPLE_BITS-1:0] re_a_s1, im_a_s1, re_a_s2, im_a_s2;
	logic tag_valid, tag_ready, m_valid, f_ready;
	fpsr_tag_t tag;
	logic [2*SAMPLE_BITS:0] odata;

	assign s_axis_tready = f_ready;

	always_ff @(posedge clk) begin
		if (f_ready) begin
			re_a_s1 <= s_axis_tdata[SB +: SAMPLE_BITS];
			im_a_s1 <= s_axis_tdata[SB+SAMPLE_BITS +: SAMPLE_BITS];
			re_a_s2 <= re_a_s1;
			im_a_s2 <= im_a_s1;
		end
	end

	fpsr_front #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE)) u_front (
		.clk, .arst_n,
		.in_valid  (s_axis_tvalid),
		.in_ready  (f_ready),
		.col_index (s_axis_tdata[IDX_BITS-1:0]),
		.row_index (s_axis_tdata[2*IDX_BITS-1:IDX_BITS]),
		.shift_col (shift_col_q),
		.shift_row (shift_row_q),
		.log2_cols (log2_cols_q),
		.log2_rows (log2_rows_q),
		.last_in   (s_axis_tlast),
		.tag_valid,
		.tag_ready,
		.tag
	);

	fpsr_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
		.clk, .arst_n,
		.tag_valid,
		.tag_ready,
		.tag,
		.re_in     (re_a_s2),
		.im_in     (im_a_s2),
		.out_valid (m_valid),
		.out_ready (m_axis_tready),
		.out_data  (odata)
	);

	assign m_axis_tvalid = m_valid;
	assign m_axis_tdata  = OW'(odata[2*SAMPLE_BITS-1:0]);
	assign m_axis_tlast  = odata[2*SAMPLE_BITS];

	// hold the front while its tag waits for the back
	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && !tag_ready |-> !s_axis_tready)
		else $error("input accepted while tag register blocked");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready) else $error("ready low with empty output");
endmodule
`default_nettype wire
